[rtl/tps_pkg.sv]
// Shared types and constants of the tracker pattern sequencer.
package tps_pkg;

  // Width of a row index and of a pattern length.
  localparam int unsigned ROW_W = 6;

  // A cell whose note has this value releases the voice.
  localparam logic [7:0] RELEASE_NOTE = 8'h80;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_CELL   = 3'd1,
    OP_ORDER  = 3'd2,
    OP_LENGTH = 3'd3,
    OP_SETUP  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    EV_RELEASE = 2'd0,
    EV_PRESS   = 2'd1,
    EV_EFFECT  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [2:0] op;
    logic [1:0] track_sel;
    logic [3:0] pattern_sel;
    logic [7:0] position;
    logic [7:0] note_in;
    logic [7:0] velocity_in;
    logic [7:0] effect_in;
    logic [7:0] amount_in;
    logic [5:0] loop_first;
    logic [5:0] loop_last;
    logic [2:0] voice_count;
    logic [5:0] length_value;
  } req_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [1:0] event_track;
    logic [1:0] event_voice;
    logic [7:0] event_note;
    logic [7:0] event_velocity;
    logic [7:0] event_effect;
    logic [7:0] event_amount;
    logic       last;
  } evt_t;

endpackage

[rtl/tps_cell_store.sv]
// Pattern cell memory: maps track, pattern and cell index to one word, one write and one read port.
module tps_cell_store #(
  parameter int unsigned TRACKS   = 4,
  parameter int unsigned PATTERNS = 16,
  parameter int unsigned CELLS    = 256
) (
  input  logic                                        clk_i,
  input  logic                                        wr_en_i,
  input  logic [((TRACKS > 1) ? $clog2(TRACKS) : 1)-1:0]   wr_track_i,
  input  logic [((PATTERNS > 1) ? $clog2(PATTERNS) : 1)-1:0] wr_pattern_i,
  input  logic [((CELLS > 1) ? $clog2(CELLS) : 1)-1:0]     wr_index_i,
  input  logic [31:0]                                 wr_data_i,
  input  logic                                        rd_en_i,
  input  logic [((TRACKS > 1) ? $clog2(TRACKS) : 1)-1:0]   rd_track_i,
  input  logic [((PATTERNS > 1) ? $clog2(PATTERNS) : 1)-1:0] rd_pattern_i,
  input  logic [((CELLS > 1) ? $clog2(CELLS) : 1)-1:0]     rd_index_i,
  output logic [31:0]                                 rd_data_o
);

  localparam int unsigned DEPTH  = TRACKS * PATTERNS * CELLS;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [31:0]       mem_q [DEPTH];
  logic [31:0]       rd_data_q;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;

  // Each track owns a block of patterns, each pattern a block of cells.
  assign wr_addr = ADDR_W'(32'(wr_track_i) * (PATTERNS * CELLS)
                   + 32'(wr_pattern_i) * CELLS + 32'(wr_index_i));
  assign rd_addr = ADDR_W'(32'(rd_track_i) * (PATTERNS * CELLS)
                   + 32'(rd_pattern_i) * CELLS + 32'(rd_index_i));

  // Synchronous write and registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/tracker_pattern_sequencer.sv]
// Tracker pattern sequencer: load requests fill the tables, tick requests play one row.
//
// A request is taken when start is high and busy is low. Load requests (cell, order entry,
// pattern length, track setup) and ticks while not playing finish in the cycle they are
// taken and leave busy low. A tick while playing walks every track in order and keeps busy
// high throughout: each track opens with a read of the order table and one of the length
// table, then each voice reads one cell from the single read port of the cell memory and
// sends its event, and an effect event too if the cell has a nonzero effect; the track
// ends by advancing its row. Each event sits on the outputs for one cycle with
// strobe_o high; the receiver cannot hold events off, and last marks the final event of
// the tick. No clearing pass runs after reset: the pattern length table keeps one valid
// bit per entry and an unwritten length reads as zero.
module tracker_pattern_sequencer #(
  parameter int unsigned TRACKS     = 4,
  parameter int unsigned PATTERNS   = 16,
  parameter int unsigned MAX_ROWS   = 64,
  parameter int unsigned MAX_VOICES = 4,
  parameter int unsigned ORDER_LEN  = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  tps_pkg::req_t req_i,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  output logic          strobe_o,
  output tps_pkg::evt_t evt_o
);

  localparam int unsigned TIDX_W    = (TRACKS > 1) ? $clog2(TRACKS) : 1;
  localparam int unsigned PAT_W     = (PATTERNS > 1) ? $clog2(PATTERNS) : 1;
  localparam int unsigned CELLS     = MAX_ROWS * MAX_VOICES;
  localparam int unsigned CI_W      = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int unsigned VC_W      = $clog2(MAX_VOICES + 1);
  localparam int unsigned OPOS_W    = (ORDER_LEN > 1) ? $clog2(ORDER_LEN) : 1;
  localparam int unsigned ORD_DEPTH = TRACKS * ORDER_LEN;
  localparam int unsigned OADDR_W   = (ORD_DEPTH > 1) ? $clog2(ORD_DEPTH) : 1;
  localparam int unsigned LEN_DEPTH = TRACKS * PATTERNS;
  localparam int unsigned LADDR_W   = (LEN_DEPTH > 1) ? $clog2(LEN_DEPTH) : 1;
  localparam int unsigned ROW_W     = tps_pkg::ROW_W;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_ORD  = 7'b0000010,
    S_PAT  = 7'b0000100,
    S_CRD  = 7'b0001000,
    S_EMIT = 7'b0010000,
    S_EFF  = 7'b0100000,
    S_ADV  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [TIDX_W-1:0] trk_q, trk_d;
  logic [VC_W-1:0]   voice_q, voice_d;
  logic              playing_q, playing_d;
  logic              strobe_q, strobe_d;
  tps_pkg::evt_t     evt_q, evt_d;

  // Per-track setup and play position.
  logic [ROW_W-1:0]  row_q [TRACKS];
  logic [ROW_W-1:0]  row_d [TRACKS];
  logic [OPOS_W-1:0] opos_q [TRACKS];
  logic [OPOS_W-1:0] opos_d [TRACKS];
  logic [OPOS_W-1:0] loop_start_q [TRACKS];
  logic [OPOS_W-1:0] loop_start_d [TRACKS];
  logic [OPOS_W-1:0] loop_end_q [TRACKS];
  logic [OPOS_W-1:0] loop_end_d [TRACKS];
  logic [VC_W-1:0]   voices_q [TRACKS];
  logic [VC_W-1:0]   voices_d [TRACKS];

  // Order table and pattern length table.
  logic [PAT_W-1:0]   ord_mem_q [ORD_DEPTH];
  logic [PAT_W-1:0]   ord_rdata_q;
  logic [ROW_W-1:0]   len_mem_q [LEN_DEPTH];
  logic [ROW_W-1:0]   len_rdata_q;
  logic [LEN_DEPTH-1:0] len_valid_q, len_valid_d;
  logic               len_ok_q;

  logic               accept;
  logic               trk_ok;
  logic               pat_ok;
  logic               cell_we;
  logic               ord_we;
  logic               len_we;
  logic               ord_re;
  logic               len_re;
  logic               cell_re;
  logic [OADDR_W-1:0] ord_waddr;
  logic [OADDR_W-1:0] ord_raddr;
  logic [LADDR_W-1:0] len_waddr;
  logic [LADDR_W-1:0] len_raddr;
  logic [ROW_W-1:0]   len_sat;
  logic [CI_W-1:0]    cell_index;
  logic [31:0]        cell_rdata;

  logic [VC_W-1:0]    cur_voices;
  logic [VC_W:0]      voice_inc;
  logic               last_voice;
  logic               later_voices;
  logic               has_effect;
  logic [ROW_W-1:0]   cur_len;
  logic [ROW_W:0]     row_inc;
  logic               row_wrap;
  logic [OPOS_W:0]    opos_inc;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);
  assign trk_ok = 32'(req_i.track_sel) < TRACKS;
  assign pat_ok = 32'(req_i.pattern_sel) < PATTERNS;

  // Load request decode: every table write happens in the cycle the request is taken.
  always_comb begin
    cell_we = 1'b0;
    ord_we  = 1'b0;
    len_we  = 1'b0;
    if (accept && trk_ok) begin
      case (req_i.op)
        tps_pkg::OP_CELL:   cell_we = pat_ok && (32'(req_i.position) < CELLS);
        tps_pkg::OP_ORDER:  ord_we  = pat_ok && (32'(req_i.position) < ORDER_LEN);
        tps_pkg::OP_LENGTH: len_we  = pat_ok;
        default: ;
      endcase
    end
  end

  assign ord_waddr = OADDR_W'(32'(req_i.track_sel) * ORDER_LEN + 32'(req_i.position));
  assign len_waddr = LADDR_W'(32'(req_i.track_sel) * PATTERNS + 32'(req_i.pattern_sel));
  assign len_sat   = (32'(req_i.length_value) > MAX_ROWS - 1) ? ROW_W'(MAX_ROWS - 1)
                                                               : req_i.length_value;

  // Table reads that open a track and the cell read of each voice.
  assign ord_re     = (state_q == S_ORD);
  assign len_re     = (state_q == S_PAT);
  assign cell_re    = (state_q == S_CRD);
  assign ord_raddr  = OADDR_W'(32'(trk_q) * ORDER_LEN + 32'(opos_q[trk_q]));
  assign len_raddr  = LADDR_W'(32'(trk_q) * PATTERNS + 32'(ord_rdata_q));
  assign cur_voices = voices_q[trk_q];
  assign cell_index = CI_W'(32'(row_q[trk_q]) * 32'(cur_voices) + 32'(voice_q));

  always_ff @(posedge clk_i) begin
    if (ord_we) begin
      ord_mem_q[ord_waddr] <= PAT_W'(req_i.pattern_sel);
    end
    if (ord_re) begin
      ord_rdata_q <= ord_mem_q[ord_raddr];
    end
    if (len_we) begin
      len_mem_q[len_waddr] <= len_sat;
    end
    if (len_re) begin
      len_rdata_q <= len_mem_q[len_raddr];
      len_ok_q    <= len_valid_q[len_raddr];
    end
  end

  tps_cell_store #(
    .TRACKS   (TRACKS),
    .PATTERNS (PATTERNS),
    .CELLS    (CELLS)
  ) u_cell_store (
    .clk_i        (clk_i),
    .wr_en_i      (cell_we),
    .wr_track_i   (TIDX_W'(req_i.track_sel)),
    .wr_pattern_i (PAT_W'(req_i.pattern_sel)),
    .wr_index_i   (CI_W'(req_i.position)),
    .wr_data_i    ({req_i.amount_in, req_i.effect_in, req_i.velocity_in, req_i.note_in}),
    .rd_en_i      (cell_re),
    .rd_track_i   (trk_q),
    .rd_pattern_i (ord_rdata_q),
    .rd_index_i   (cell_index),
    .rd_data_o    (cell_rdata)
  );

  // Lookahead for the last flag: does any later track still have voices?
  always_comb begin
    later_voices = 1'b0;
    for (int i = 0; i < TRACKS; i++) begin
      if ((32'(trk_q) < i) && (voices_q[i] != '0)) begin
        later_voices = 1'b1;
      end
    end
  end

  assign voice_inc  = (VC_W + 1)'(voice_q) + 1'b1;
  assign last_voice = (voice_inc == {1'b0, cur_voices});
  assign has_effect = (cell_rdata[23:16] != 8'd0);

  // Row and order advance of the current track.
  assign cur_len  = len_ok_q ? len_rdata_q : '0;
  assign row_inc  = {1'b0, row_q[trk_q]} + 1'b1;
  assign row_wrap = row_inc > {1'b0, cur_len};
  assign opos_inc = {1'b0, opos_q[trk_q]} + (OPOS_W + 1)'(row_wrap);

  // Sequencer and register updates.
  always_comb begin
    state_d      = state_q;
    trk_d        = trk_q;
    voice_d      = voice_q;
    playing_d    = cfg_we_i ? cfg_wdata_i : playing_q;
    strobe_d     = 1'b0;
    evt_d        = evt_q;
    row_d        = row_q;
    opos_d       = opos_q;
    loop_start_d = loop_start_q;
    loop_end_d   = loop_end_q;
    voices_d     = voices_q;
    len_valid_d  = len_valid_q;

    if (len_we) begin
      len_valid_d[len_waddr] = 1'b1;
    end

    case (state_q)
      S_IDLE: begin
        if (accept && (req_i.op == tps_pkg::OP_TICK) && playing_q) begin
          trk_d   = '0;
          state_d = S_ORD;
        end else if (accept && trk_ok && (req_i.op == tps_pkg::OP_SETUP)) begin
          loop_start_d[req_i.track_sel] = (32'(req_i.loop_first) > ORDER_LEN - 1) ?
                                          OPOS_W'(ORDER_LEN - 1) : OPOS_W'(req_i.loop_first);
          loop_end_d[req_i.track_sel]   = (32'(req_i.loop_last) > ORDER_LEN - 1) ?
                                          OPOS_W'(ORDER_LEN - 1) : OPOS_W'(req_i.loop_last);
          voices_d[req_i.track_sel]     = (32'(req_i.voice_count) > MAX_VOICES) ?
                                          VC_W'(MAX_VOICES) : VC_W'(req_i.voice_count);
        end
      end
      S_ORD: begin
        state_d = S_PAT;
      end
      S_PAT: begin
        voice_d = '0;
        state_d = (cur_voices == '0) ? S_ADV : S_CRD;
      end
      S_CRD: begin
        state_d = S_EMIT;
      end
      S_EMIT, S_EFF: begin
        strobe_d             = 1'b1;
        evt_d.event_track    = 2'(trk_q);
        evt_d.event_voice    = 2'(voice_q);
        evt_d.event_note     = cell_rdata[7:0];
        evt_d.event_velocity = cell_rdata[15:8];
        evt_d.event_effect   = cell_rdata[23:16];
        evt_d.event_amount   = cell_rdata[31:24];
        if ((state_q == S_EMIT) && has_effect) begin
          evt_d.event_kind = (cell_rdata[7:0] == tps_pkg::RELEASE_NOTE) ?
                             2'(tps_pkg::EV_RELEASE) : 2'(tps_pkg::EV_PRESS);
          evt_d.last       = 1'b0;
          state_d          = S_EFF;
        end else begin
          if (state_q == S_EMIT) begin
            evt_d.event_kind = (cell_rdata[7:0] == tps_pkg::RELEASE_NOTE) ?
                               2'(tps_pkg::EV_RELEASE) : 2'(tps_pkg::EV_PRESS);
          end else begin
            evt_d.event_kind = 2'(tps_pkg::EV_EFFECT);
          end
          evt_d.last = last_voice && !later_voices;
          if (last_voice) begin
            state_d = S_ADV;
          end else begin
            voice_d = VC_W'(voice_inc);
            state_d = S_CRD;
          end
        end
      end
      S_ADV: begin
        row_d[trk_q]  = row_wrap ? '0 : row_inc[ROW_W-1:0];
        opos_d[trk_q] = (opos_inc > {1'b0, loop_end_q[trk_q]}) ? loop_start_q[trk_q]
                                                                 : opos_inc[OPOS_W-1:0];
        if (32'(trk_q) == TRACKS - 1) begin
          state_d = S_IDLE;
        end else begin
          trk_d   = trk_q + 1'b1;
          state_d = S_ORD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state and per-track registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      trk_q       <= '0;
      voice_q     <= '0;
      playing_q   <= 1'b0;
      strobe_q    <= 1'b0;
      len_valid_q <= '0;
      for (int i = 0; i < TRACKS; i++) begin
        row_q[i]        <= '0;
        opos_q[i]       <= '0;
        loop_start_q[i] <= '0;
        loop_end_q[i]   <= '0;
        voices_q[i]     <= '0;
      end
    end else begin
      state_q      <= state_d;
      trk_q        <= trk_d;
      voice_q      <= voice_d;
      playing_q    <= playing_d;
      strobe_q     <= strobe_d;
      len_valid_q  <= len_valid_d;
      row_q        <= row_d;
      opos_q       <= opos_d;
      loop_start_q <= loop_start_d;
      loop_end_q   <= loop_end_d;
      voices_q     <= voices_d;
    end
  end

  // Event payload register.
  always_ff @(posedge clk_i) begin
    evt_q <= evt_d;
  end

  assign strobe_o = strobe_q;
  assign evt_o    = evt_q;

endmodule

[tb/tb_tracker_pattern_sequencer.sv]
// Self-checking random testbench of the tracker pattern sequencer with a scoreboard predictor.
`timescale 1ns / 1ps

module tb_tracker_pattern_sequencer;

  localparam int TRACKS     = 4;
  localparam int PATTERNS   = 16;
  localparam int MAX_ROWS   = 64;
  localparam int MAX_VOICES = 4;
  localparam int ORDER_LEN  = 64;

  // Op codes that the block does not know and must ignore.
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  // Cycles a busy tick can last with the default sizes, rounded up.
  localparam int TICK_CYCLES = 64;

  // Requests sent in each random phase; with the directed part this gives about 470.
  localparam int PHASE_REQUESTS = 74;

  // Keeps a copy of the sequencer state and the events that are still due.
  class playback_scoreboard;
    logic [31:0] cells     [TRACKS][PATTERNS][MAX_ROWS * MAX_VOICES];
    bit          cell_set  [TRACKS][PATTERNS][MAX_ROWS * MAX_VOICES];
    logic [3:0]  order     [TRACKS][ORDER_LEN];
    bit          order_set [TRACKS][ORDER_LEN];
    logic [5:0]  last_row  [TRACKS][PATTERNS];
    logic [5:0]  loop_start [TRACKS];
    logic [5:0]  loop_end   [TRACKS];
    logic [2:0]  voices     [TRACKS];
    logic [5:0]  row        [TRACKS];
    logic [6:0]  order_pos  [TRACKS];
    bit          playing;
    tps_pkg::evt_t due_events [$];
    int          mismatches;

    function new();
      foreach (last_row[t, p]) last_row[t][p] = '0;
      foreach (voices[t]) begin
        loop_start[t] = '0;
        loop_end[t]   = '0;
        voices[t]     = '0;
        row[t]        = '0;
        order_pos[t]  = '0;
      end
      playing    = 1'b0;
      mismatches = 0;
    endfunction

    task flag_mismatch(string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task compare_field(string field, logic [7:0] got, logic [7:0] want);
      if (got !== want) begin
        flag_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", field, got, want));
      end
    endtask

    // Plays one row on every track and queues the events it causes.
    function void play_row();
      tps_pkg::evt_t batch [$];
      tps_pkg::evt_t e;
      int          oi;
      int          p;
      int          nv;
      int          ci;
      int          nxt;
      logic [31:0] c;
      for (int t = 0; t < TRACKS; t++) begin
        oi = order_pos[t] % ORDER_LEN;
        p  = int'(order[t][oi]);
        nv = int'(voices[t]);
        for (int v = 0; v < nv; v++) begin
          ci = int'(row[t]) * nv + v;
          c  = cells[t][p][ci];
          e.event_kind     = (c[7:0] == tps_pkg::RELEASE_NOTE) ? tps_pkg::EV_RELEASE
                                                               : tps_pkg::EV_PRESS;
          e.event_track    = 2'(t);
          e.event_voice    = 2'(v);
          e.event_note     = c[7:0];
          e.event_velocity = c[15:8];
          e.event_effect   = c[23:16];
          e.event_amount   = c[31:24];
          e.last           = 1'b0;
          batch.push_back(e);
          if (c[23:16] != 8'd0) begin
            e.event_kind = tps_pkg::EV_EFFECT;
            batch.push_back(e);
          end
        end
        // Advance the row, then the order entry, then apply the loop range.
        nxt = int'(row[t]) + 1;
        if (nxt > int'(last_row[t][p])) begin
          nxt          = 0;
          order_pos[t] = order_pos[t] + 7'd1;
        end
        row[t] = 6'(nxt);
        if (order_pos[t] > {1'b0, loop_end[t]}) begin
          order_pos[t] = {1'b0, loop_start[t]};
        end
      end
      if (batch.size() > 0) begin
        batch[batch.size() - 1].last = 1'b1;
      end
      foreach (batch[i]) due_events.push_back(batch[i]);
    endfunction

    // Updates the state for one accepted request.
    function void take_request(tps_pkg::req_t r);
      case (r.op)
        tps_pkg::OP_TICK: begin
          if (playing) begin
            play_row();
          end
        end
        tps_pkg::OP_CELL: begin
          cells[r.track_sel][r.pattern_sel][r.position] =
            {r.amount_in, r.effect_in, r.velocity_in, r.note_in};
          cell_set[r.track_sel][r.pattern_sel][r.position] = 1'b1;
        end
        tps_pkg::OP_ORDER: begin
          if (r.position < ORDER_LEN) begin
            order[r.track_sel][r.position]     = r.pattern_sel;
            order_set[r.track_sel][r.position] = 1'b1;
          end
        end
        tps_pkg::OP_LENGTH: begin
          last_row[r.track_sel][r.pattern_sel] =
            (r.length_value > MAX_ROWS - 1) ? 6'(MAX_ROWS - 1) : r.length_value;
        end
        tps_pkg::OP_SETUP: begin
          loop_start[r.track_sel] =
            (r.loop_first > ORDER_LEN - 1) ? 6'(ORDER_LEN - 1) : r.loop_first;
          loop_end[r.track_sel] =
            (r.loop_last > ORDER_LEN - 1) ? 6'(ORDER_LEN - 1) : r.loop_last;
          voices[r.track_sel] =
            (r.voice_count > MAX_VOICES) ? 3'(MAX_VOICES) : r.voice_count;
        end
        default: begin
        end
      endcase
    endfunction

    // Finds the first order entry or cell that the next tick would read unwritten.
    function bit first_unwritten_read(output int trk, output int pat, output int idx,
                                      output bit in_cells);
      int oi;
      int p;
      int nv;
      int ci;
      for (int t = 0; t < TRACKS; t++) begin
        oi = order_pos[t] % ORDER_LEN;
        if (!order_set[t][oi]) begin
          trk      = t;
          pat      = 0;
          idx      = oi;
          in_cells = 1'b0;
          return 1'b1;
        end
        p  = int'(order[t][oi]);
        nv = int'(voices[t]);
        for (int v = 0; v < nv; v++) begin
          ci = int'(row[t]) * nv + v;
          if (!cell_set[t][p][ci]) begin
            trk      = t;
            pat      = p;
            idx      = ci;
            in_cells = 1'b1;
            return 1'b1;
          end
        end
      end
      return 1'b0;
    endfunction

    // Compares one event from the block with the oldest one due.
    task check_event(tps_pkg::evt_t got);
      tps_pkg::evt_t want;
      if (due_events.size() == 0) begin
        flag_mismatch("event while none was due");
        return;
      end
      want = due_events.pop_front();
      compare_field("event_kind", 8'(got.event_kind), 8'(want.event_kind));
      compare_field("event_track", 8'(got.event_track), 8'(want.event_track));
      compare_field("event_voice", 8'(got.event_voice), 8'(want.event_voice));
      compare_field("event_note", got.event_note, want.event_note);
      compare_field("event_velocity", got.event_velocity, want.event_velocity);
      compare_field("event_effect", got.event_effect, want.event_effect);
      compare_field("event_amount", got.event_amount, want.event_amount);
      compare_field("last", 8'(got.last), 8'(want.last));
    endtask
  endclass

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic start       = 1'b0;
  logic cfg_we_i    = 1'b0;
  logic cfg_wdata_i = 1'b0;
  tps_pkg::req_t req_i = '0;
  logic busy;
  logic strobe_o;
  tps_pkg::evt_t evt_o;

  playback_scoreboard sb = new();
  int idle_pct = 0;
  int counted  = 0;

  tracker_pattern_sequencer i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .strobe_o   (strobe_o),
    .evt_o      (evt_o)
  );

  always #1 clk_i = ~clk_i;

  // Every event on the outputs is checked at the edge that ends its cycle.
  always @(posedge clk_i) begin
    if (rst_ni && strobe_o) begin
      sb.check_event(evt_o);
    end
  end

  // A request with every field random; callers then set the fields that matter.
  function automatic tps_pkg::req_t rand_req();
    logic [95:0] bits;
    bits = {$urandom, $urandom, $urandom};
    return bits[$bits(tps_pkg::req_t)-1:0];
  endfunction

  // Cell contents with releases and effect-free cells well represented.
  function automatic logic [31:0] rand_cell();
    logic [7:0] note;
    logic [7:0] eff;
    note = ($urandom_range(3) == 0) ? tps_pkg::RELEASE_NOTE : 8'($urandom);
    eff  = ($urandom_range(1) == 0) ? 8'd0 : 8'($urandom);
    return {8'($urandom), eff, 8'($urandom), note};
  endfunction

  // Holds start low for a random gap, then offers the request until it is taken.
  task automatic issue(tps_pkg::req_t r);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    counted++;
    sb.take_request(r);
  endtask

  task automatic put_cell(int trk, int pat, int pos, logic [31:0] c);
    tps_pkg::req_t r;
    r = rand_req();
    r.op          = tps_pkg::OP_CELL;
    r.track_sel   = 2'(trk);
    r.pattern_sel = 4'(pat);
    r.position    = 8'(pos);
    {r.amount_in, r.effect_in, r.velocity_in, r.note_in} = c;
    issue(r);
  endtask

  task automatic put_order(int trk, int idx, int pat);
    tps_pkg::req_t r;
    r = rand_req();
    r.op          = tps_pkg::OP_ORDER;
    r.track_sel   = 2'(trk);
    r.position    = 8'(idx);
    r.pattern_sel = 4'(pat);
    issue(r);
  endtask

  task automatic put_length(int trk, int pat, int len);
    tps_pkg::req_t r;
    r = rand_req();
    r.op           = tps_pkg::OP_LENGTH;
    r.track_sel    = 2'(trk);
    r.pattern_sel  = 4'(pat);
    r.length_value = 6'(len);
    issue(r);
  endtask

  task automatic put_setup(int trk, int lf, int ll, int vc);
    tps_pkg::req_t r;
    r = rand_req();
    r.op          = tps_pkg::OP_SETUP;
    r.track_sel   = 2'(trk);
    r.loop_first  = 6'(lf);
    r.loop_last   = 6'(ll);
    r.voice_count = 3'(vc);
    issue(r);
  endtask

  task automatic put_unused_op();
    tps_pkg::req_t r;
    r = rand_req();
    r.op = 3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
    issue(r);
  endtask

  // Writes whatever the next tick would read unwritten, then sends the tick.
  task automatic put_tick();
    tps_pkg::req_t r;
    int   trk;
    int   pat;
    int   idx;
    bit   in_cells;
    forever begin
      if (!sb.playing) break;
      if (!sb.first_unwritten_read(trk, pat, idx, in_cells)) break;
      if (in_cells) begin
        put_cell(trk, pat, idx, rand_cell());
      end else begin
        put_order(trk, idx, $urandom_range(PATTERNS - 1));
      end
    end
    r = rand_req();
    r.op = tps_pkg::OP_TICK;
    issue(r);
  endtask

  // Waits until the block is done, then writes the playing register.
  task automatic settle_and_play(bit value);
    start <= 1'b0;
    while (sb.due_events.size() != 0 || busy) @(posedge clk_i);
    repeat (TICK_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    sb.playing = value;
    cfg_we_i <= 1'b0;
  endtask

  // One random request; small patterns, rows and loops keep playback wrapping often.
  task automatic random_item();
    int pick;
    int pat;
    pick = $urandom_range(99);
    pat  = ($urandom_range(1) == 0) ? $urandom_range(3) : $urandom_range(PATTERNS - 1);
    if (pick < 35) begin
      put_tick();
    end else if (pick < 55) begin
      put_cell($urandom_range(TRACKS - 1), pat,
               ($urandom_range(1) == 0) ? $urandom_range(15) : $urandom_range(255),
               rand_cell());
    end else if (pick < 70) begin
      put_order($urandom_range(TRACKS - 1),
                ($urandom_range(4) == 0) ? $urandom_range(255) : $urandom_range(7), pat);
    end else if (pick < 80) begin
      put_length($urandom_range(TRACKS - 1), pat,
                 ($urandom_range(9) < 7) ? $urandom_range(3) : $urandom_range(MAX_ROWS - 1));
    end else if (pick < 92) begin
      put_setup($urandom_range(TRACKS - 1),
                ($urandom_range(4) == 0) ? $urandom_range(63) : $urandom_range(7),
                ($urandom_range(4) == 0) ? $urandom_range(63) : $urandom_range(7),
                $urandom_range(7));
    end else begin
      put_unused_op();
    end
  endtask

  // Playing setting and sender idle percentage of each random phase.
  bit play_plan [6] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
  int idle_plan [6] = '{0, 77, 33, 77, 0, 33};

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: a tick while stopped, setup extremes, ignored writes, edge cells.
    put_tick();
    put_setup(0, 0, 1, 2);
    put_setup(1, 3, 2, 7);
    put_setup(2, 63, 63, 0);
    put_setup(3, 0, 0, 1);
    put_order(0, 0, 15);
    put_order(0, 1, 0);
    put_order(0, 63, 5);
    put_order(1, 255, 9);
    put_length(0, 15, 0);
    put_length(0, 0, 63);
    put_length(1, 0, 1);
    put_cell(0, 15, 0, {8'h00, 8'h00, 8'h00, tps_pkg::RELEASE_NOTE});
    put_cell(0, 15, 1, 32'hFFFF_FFFF);
    put_cell(3, 0, 255, 32'h0000_0000);
    put_unused_op();
    settle_and_play(1'b1);
    repeat (6) put_tick();

    // Random phases with different playing settings and sender gaps.
    foreach (play_plan[ph]) begin
      settle_and_play(play_plan[ph]);
      idle_pct = idle_plan[ph];
      counted  = 0;
      while (counted < PHASE_REQUESTS) random_item();
    end

    // Drain the remaining events and give the block time to go quiet.
    start <= 1'b0;
    while (sb.due_events.size() != 0) @(posedge clk_i);
    repeat (TICK_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.due_events.size() == 0) begin
      $display("tracker_pattern_sequencer regression: pass");
    end else begin
      $display("tracker_pattern_sequencer regression: fail");
    end
    $finish;
  end

  // Ends a run that hangs.
  initial begin
    #2000000;
    $display("tracker_pattern_sequencer regression: fail");
    $finish;
  end

endmodule

[sim.f]
rtl/tps_pkg.sv
rtl/tps_cell_store.sv
rtl/tracker_pattern_sequencer.sv
tb/tb_tracker_pattern_sequencer.sv
